// ===== hw/rtl/tps_pkg.sv =====
// Shared widths, register indexes and types of the triangle pixel shader.
package tps_pkg;

  localparam int unsigned CANVAS_LIMIT_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int POS_W      = 48;
  localparam int COORD_W    = 24;
  localparam int COLOR_W    = 32;
  localparam int CANVAS_W   = 13;
  localparam int PIX_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX0_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX1_POS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX2_POS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX0_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX1_COL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX2_COL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H    = 3'd7;

  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 13'd256;

  // Datapath widths
  localparam int DIFF_W  = 25;   // vertex and pixel differences
  localparam int PROD_W  = 50;   // edge products
  localparam int EDGE_W  = 51;   // signed edge and area values
  localparam int MAG_W   = 49;   // weights and area once covered
  localparam int SUM_W   = 57;   // weighted channel sums
  localparam int SLO_W   = 29;
  localparam int SHI_W   = 28;
  localparam int ALO_W   = 25;
  localparam int AHI_W   = 24;
  localparam int PP_W    = 114;  // channel sum times alpha sum
  localparam int AA_W    = 98;   // area squared
  localparam int SQ_W    = 106;  // 255 * area squared
  localparam int NUM_W   = 116;
  localparam int DEN_W   = 107;
  localparam int ANUM_W  = 59;
  localparam int ADEN_W  = 50;
  localparam int QUO_W   = 9;
  localparam int DIV_STEPS = 9;
  localparam int PRE_STAGES = 11;
  localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             ok;
  } tag_t;

endpackage

// ===== hw/rtl/triangle_pixel_shader.sv =====
// Triangle pixel shader top level: edge test and Gouraud colour pipeline.
// One pixel enters per clock while the input is not stalled; every stage
// holds at most one pixel and moves on when the stage after it has room, so a
// stalled output fills the pipeline before the input stalls. The pipeline ends in
// the nine compare-and-subtract steps of the rounding division that turns the
// weighted colour sums into 8-bit channels. Configuration writes take effect at
// once and are always ready.
module triangle_pixel_shader #(
  parameter int unsigned CANVAS_LIMIT = tps_pkg::CANVAS_LIMIT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tps_pkg::PIX_W-1:0]      pixel_col_i,
  input  logic [tps_pkg::PIX_W-1:0]      pixel_row_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           covered_o,
  output logic [31:0]                    source_argb_o,
  output logic [tps_pkg::PIX_W-1:0]      out_col_o,
  output logic [tps_pkg::PIX_W-1:0]      out_row_o
);
  import tps_pkg::*;

  // Configuration registers
  logic [POS_W-1:0]    pos_q [3];
  logic [COLOR_W-1:0]  color_q [3];
  logic [CANVAS_W-1:0] canvas_w_q, canvas_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i]   <= '0;
        color_q[i] <= '0;
      end
      canvas_w_q <= CANVAS_RESET;
      canvas_h_q <= CANVAS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VERTEX0_POS: pos_q[0]   <= cfg_data_i;
        REG_VERTEX1_POS: pos_q[1]   <= cfg_data_i;
        REG_VERTEX2_POS: pos_q[2]   <= cfg_data_i;
        REG_VERTEX0_COL: color_q[0] <= cfg_data_i[COLOR_W-1:0];
        REG_VERTEX1_COL: color_q[1] <= cfg_data_i[COLOR_W-1:0];
        REG_VERTEX2_COL: color_q[2] <= cfg_data_i[COLOR_W-1:0];
        REG_CANVAS_W:    canvas_w_q <= cfg_data_i[CANVAS_W-1:0];
        REG_CANVAS_H:    canvas_h_q <= cfg_data_i[CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;
  tag_t                  tag_q [NUM_STAGES];
  tag_t                  tag_d [NUM_STAGES];

  always_comb begin
    en[NUM_STAGES] = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        tag_q[k] <= tag_d[k];
      end
    end
  end

  // Stage 1: differences
  logic signed [COORD_W-1:0] vx [3], vy [3];
  logic signed [20:0]        px, py;
  logic signed [DIFF_W-1:0]  dx_d [3], dy_d [3], ex_d [3], ey_d [3];
  logic signed [DIFF_W-1:0]  dx_q [3], dy_q [3], ex_q [3], ey_q [3];
  logic                      in_canvas;

  always_comb begin
    px = $signed({1'b0, pixel_col_i, 8'h80});
    py = $signed({1'b0, pixel_row_i, 8'h80});
    for (int i = 0; i < 3; i++) begin
      vx[i] = $signed(pos_q[i][COORD_W-1:0]);
      vy[i] = $signed(pos_q[i][POS_W-1:COORD_W]);
    end
    for (int i = 0; i < 3; i++) begin
      dx_d[i] = DIFF_W'(vx[(i+2)%3]) - DIFF_W'(vx[(i+1)%3]);
      dy_d[i] = DIFF_W'(vy[(i+2)%3]) - DIFF_W'(vy[(i+1)%3]);
      ex_d[i] = DIFF_W'(px) - DIFF_W'(vx[(i+1)%3]);
      ey_d[i] = DIFF_W'(py) - DIFF_W'(vy[(i+1)%3]);
    end
    in_canvas = ({1'b0, pixel_col_i} < canvas_w_q) && ({1'b0, pixel_row_i} < canvas_h_q)
             && (32'(pixel_col_i) < CANVAS_LIMIT) && (32'(pixel_row_i) < CANVAS_LIMIT);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      ex_q <= ex_d;
      ey_q <= ey_d;
    end
  end

  // Stage 2: edge and area products
  logic signed [PROD_W-1:0] m1_d [3], m2_d [3], m1_q [3], m2_q [3];
  logic signed [PROD_W-1:0] ma1_d, ma2_d, ma1_q, ma2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_d[i] = dx_q[i] * ey_q[i];
      m2_d[i] = dy_q[i] * ex_q[i];
    end
    ma1_d = dx_q[0] * dy_q[1];
    ma2_d = dx_q[1] * dy_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      ma1_q <= ma1_d;
      ma2_q <= ma2_d;
    end
  end

  // Stage 3: edge functions and area
  logic signed [EDGE_W-1:0] w_d [3], w_q [3];
  logic signed [EDGE_W-1:0] area_d, area_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_d[i] = EDGE_W'(m1_q[i]) - EDGE_W'(m2_q[i]);
    end
    area_d = EDGE_W'(ma1_q) - EDGE_W'(ma2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      w_q    <= w_d;
      area_q <= area_d;
    end
  end

  // Stage 4: orient by area sign, coverage test
  logic signed [EDGE_W-1:0] wn [3];
  logic signed [EDGE_W-1:0] an;
  logic [MAG_W-1:0]         wm_d [3], wm_q [3];
  logic [MAG_W-1:0]         am_d, am_q;
  logic                     cov;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wn[i]   = area_q[EDGE_W-1] ? -w_q[i] : w_q[i];
      wm_d[i] = wn[i][MAG_W-1:0];
    end
    an   = area_q[EDGE_W-1] ? -area_q : area_q;
    am_d = an[MAG_W-1:0];
    cov  = tag_q[2].ok && (area_q != '0)
        && !wn[0][EDGE_W-1] && !wn[1][EDGE_W-1] && !wn[2][EDGE_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      wm_q <= wm_d;
      am_q <= am_d;
    end
  end

  // Stage 5: weight times channel
  logic [SUM_W-1:0] wc_d [4][3], wc_q [4][3];
  logic [MAG_W-1:0] am5_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        wc_d[k][i] = SUM_W'(wm_q[i]) * SUM_W'(color_q[i][31-8*k -: 8]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      wc_q  <= wc_d;
      am5_q <= am_q;
    end
  end

  // Stage 6: weighted sums
  logic [SUM_W-1:0] s_d [4], s_q [4];
  logic [MAG_W-1:0] am6_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_d[k] = wc_q[k][0] + wc_q[k][1] + wc_q[k][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s_q   <= s_d;
      am6_q <= am5_q;
    end
  end

  // Stage 7: partial products, alpha numerator and denominator
  logic [2*SLO_W-1:0]       ll_d [3], ll_q [3];
  logic [SLO_W+SHI_W-1:0]   lh_d [3], lh_q [3], hl_d [3], hl_q [3];
  logic [2*SHI_W-1:0]       hh_d [3], hh_q [3];
  logic [2*ALO_W-1:0]       all_d, all_q;
  logic [ALO_W+AHI_W-1:0]   alh_d, alh_q, ahl_d, ahl_q;
  logic [2*AHI_W-1:0]       ahh_d, ahh_q;
  logic [ANUM_W-1:0]        anum_d, anum7_q;
  logic [ADEN_W-1:0]        aden_d, aden7_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ll_d[k] = (2*SLO_W)'(s_q[k+1][SLO_W-1:0]) * (2*SLO_W)'(s_q[0][SLO_W-1:0]);
      lh_d[k] = (SLO_W+SHI_W)'(s_q[k+1][SLO_W-1:0]) * (SLO_W+SHI_W)'(s_q[0][SUM_W-1:SLO_W]);
      hl_d[k] = (SLO_W+SHI_W)'(s_q[k+1][SUM_W-1:SLO_W]) * (SLO_W+SHI_W)'(s_q[0][SLO_W-1:0]);
      hh_d[k] = (2*SHI_W)'(s_q[k+1][SUM_W-1:SLO_W]) * (2*SHI_W)'(s_q[0][SUM_W-1:SLO_W]);
    end
    all_d  = (2*ALO_W)'(am6_q[ALO_W-1:0]) * (2*ALO_W)'(am6_q[ALO_W-1:0]);
    alh_d  = (ALO_W+AHI_W)'(am6_q[ALO_W-1:0]) * (ALO_W+AHI_W)'(am6_q[MAG_W-1:ALO_W]);
    ahl_d  = (ALO_W+AHI_W)'(am6_q[MAG_W-1:ALO_W]) * (ALO_W+AHI_W)'(am6_q[ALO_W-1:0]);
    ahh_d  = (2*AHI_W)'(am6_q[MAG_W-1:ALO_W]) * (2*AHI_W)'(am6_q[MAG_W-1:ALO_W]);
    anum_d = (ANUM_W'(s_q[0]) << 1) + ANUM_W'(am6_q);
    aden_d = ADEN_W'(am6_q) << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      ll_q    <= ll_d;
      lh_q    <= lh_d;
      hl_q    <= hl_d;
      hh_q    <= hh_d;
      all_q   <= all_d;
      alh_q   <= alh_d;
      ahl_q   <= ahl_d;
      ahh_q   <= ahh_d;
      anum7_q <= anum_d;
      aden7_q <= aden_d;
    end
  end

  // Stage 8: middle terms
  logic [SLO_W+SHI_W:0]   mid_d [3], mid_q [3];
  logic [2*SLO_W-1:0]     ll8_q [3];
  logic [2*SHI_W-1:0]     hh8_q [3];
  logic [ALO_W+AHI_W:0]   amid_d, amid_q;
  logic [2*ALO_W-1:0]     all8_q;
  logic [2*AHI_W-1:0]     ahh8_q;
  logic [ANUM_W-1:0]      anum8_q;
  logic [ADEN_W-1:0]      aden8_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mid_d[k] = (SLO_W+SHI_W+1)'(lh_q[k]) + (SLO_W+SHI_W+1)'(hl_q[k]);
    end
    amid_d = (ALO_W+AHI_W+1)'(alh_q) + (ALO_W+AHI_W+1)'(ahl_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      mid_q   <= mid_d;
      ll8_q   <= ll_q;
      hh8_q   <= hh_q;
      amid_q  <= amid_d;
      all8_q  <= all_q;
      ahh8_q  <= ahh_q;
      anum8_q <= anum7_q;
      aden8_q <= aden7_q;
    end
  end

  // Stage 9: full products
  logic [PP_W-1:0]   pp_d [3], pp_q [3];
  logic [AA_W-1:0]   aa_d, aa_q;
  logic [ANUM_W-1:0] anum9_q;
  logic [ADEN_W-1:0] aden9_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp_d[k] = {hh8_q[k], ll8_q[k]} + (PP_W'(mid_q[k]) << SLO_W);
    end
    aa_d = {ahh8_q, all8_q} + (AA_W'(amid_q) << ALO_W);
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      pp_q    <= pp_d;
      aa_q    <= aa_d;
      anum9_q <= anum8_q;
      aden9_q <= aden8_q;
    end
  end

  // Stage 10: 255 times area squared
  logic [SQ_W-1:0]   sq_d, sq_q;
  logic [PP_W-1:0]   pp10_q [3];
  logic [ANUM_W-1:0] anum10_q;
  logic [ADEN_W-1:0] aden10_q;

  assign sq_d = (SQ_W'(aa_q) << 8) - SQ_W'(aa_q);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      sq_q     <= sq_d;
      pp10_q   <= pp_q;
      anum10_q <= anum9_q;
      aden10_q <= aden9_q;
    end
  end

  // Stage 11: rounding numerators and denominator
  logic [NUM_W-1:0]  num_d [3], num_q [3];
  logic [DEN_W-1:0]  den_d, den_q;
  logic [ANUM_W-1:0] anum11_q;
  logic [ADEN_W-1:0] aden11_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = (NUM_W'(pp10_q[k]) << 1) + NUM_W'(sq_q);
    end
    den_d = DEN_W'(sq_q) << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      num_q    <= num_d;
      den_q    <= den_d;
      anum11_q <= anum10_q;
      aden11_q <= aden10_q;
    end
  end

  // Tags travel with the data; coverage replaces the canvas flag in stage 4
  always_comb begin
    tag_d[0].col = pixel_col_i;
    tag_d[0].row = pixel_row_i;
    tag_d[0].ok  = in_canvas;
    for (int k = 1; k < NUM_STAGES; k++) begin
      tag_d[k] = tag_q[k-1];
    end
    tag_d[3].ok = cov;
  end

  // Stages 12 to 20: restoring division, one quotient bit per stage
  logic [NUM_W-1:0]  drem_q [DIV_STEPS][3];
  logic [QUO_W-1:0]  dquo_q [DIV_STEPS][3];
  logic [DEN_W-1:0]  dden_q [DIV_STEPS];
  logic [ANUM_W-1:0] arem_q [DIV_STEPS];
  logic [QUO_W-1:0]  aquo_q [DIV_STEPS];
  logic [ADEN_W-1:0] aden_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int Shift = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0]  rem_s [3];
    logic [QUO_W-1:0]  quo_s [3];
    logic [DEN_W-1:0]  den_s;
    logic [ANUM_W-1:0] arem_s;
    logic [QUO_W-1:0]  aquo_s;
    logic [ADEN_W-1:0] aden_s;
    logic [NUM_W-1:0]  trial;
    logic [ANUM_W-1:0] atrial;
    logic [NUM_W-1:0]  rem_d [3];
    logic [QUO_W-1:0]  quo_d [3];
    logic [ANUM_W-1:0] arem_d;
    logic [QUO_W-1:0]  aquo_d;

    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_s[k] = num_q[k];
          quo_s[k] = '0;
        end
        den_s  = den_q;
        arem_s = anum11_q;
        aquo_s = '0;
        aden_s = aden11_q;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_s[k] = drem_q[j-1][k];
          quo_s[k] = dquo_q[j-1][k];
        end
        den_s  = dden_q[j-1];
        arem_s = arem_q[j-1];
        aquo_s = aquo_q[j-1];
        aden_s = aden_q[j-1];
      end
    end

    always_comb begin
      trial  = NUM_W'(den_s) << Shift;
      atrial = ANUM_W'(aden_s) << Shift;
      for (int k = 0; k < 3; k++) begin
        if (rem_s[k] >= trial) begin
          rem_d[k] = rem_s[k] - trial;
          quo_d[k] = {quo_s[k][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[k] = rem_s[k];
          quo_d[k] = {quo_s[k][QUO_W-2:0], 1'b0};
        end
      end
      if (arem_s >= atrial) begin
        arem_d = arem_s - atrial;
        aquo_d = {aquo_s[QUO_W-2:0], 1'b1};
      end else begin
        arem_d = arem_s;
        aquo_d = {aquo_s[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[PRE_STAGES+j]) begin
        drem_q[j] <= rem_d;
        dquo_q[j] <= quo_d;
        dden_q[j] <= den_s;
        arem_q[j] <= arem_d;
        aquo_q[j] <= aquo_d;
        aden_q[j] <= aden_s;
      end
    end
  end

  // Output beat
  assign out_valid_o   = v_q[NUM_STAGES-1];
  assign covered_o     = tag_q[NUM_STAGES-1].ok;
  assign out_col_o     = tag_q[NUM_STAGES-1].col;
  assign out_row_o     = tag_q[NUM_STAGES-1].row;
  assign source_argb_o = tag_q[NUM_STAGES-1].ok
                       ? {aquo_q[DIV_STEPS-1][7:0], dquo_q[DIV_STEPS-1][0][7:0],
                          dquo_q[DIV_STEPS-1][1][7:0], dquo_q[DIV_STEPS-1][2][7:0]}
                       : 32'd0;

endmodule
